// ----- rtl/core/random_sample_without_replacement_macros.svh -----
// Assertion macros shared by the random sample block.
`ifndef RANDOM_SAMPLE_WITHOUT_REPLACEMENT_MACROS_SVH
`define RANDOM_SAMPLE_WITHOUT_REPLACEMENT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RSWR_ASSERT_IMPLIES(name, clk, rst_n, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled during reset.
`define RSWR_ASSERT_NEXT(name, clk, rst_n, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("next-cycle implication failed");

`endif

// ----- rtl/core/rswr_pkg.sv -----
// Types and constants shared by the random sample block.
package rswr_pkg;

    // Field widths
    localparam int WORD_W    = 31;
    localparam int CFG_W     = 11;
    localparam int NODE_W    = 10;
    localparam int CFG_IDX_W = 2;
    localparam int EPOCH_W   = 8;
    localparam int ENTRY_W   = EPOCH_W + NODE_W;

    // Divider runs one quotient bit per step
    localparam int DIV_STEPS = WORD_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RESERVE_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CORNER_MODE   = 2'd2;

    // Configuration reset values
    localparam logic [CFG_W-1:0] NODE_COUNT_RST    = 11'd1024;
    localparam logic [CFG_W-1:0] RESERVE_COUNT_RST = 11'd2;

    // Epoch tags: zero marks a cleared entry, the last value forces a sweep
    localparam logic [EPOCH_W-1:0] EPOCH_CLEAR = '0;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 8'd1;
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

    // One pool entry as stored in memory
    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic [NODE_W-1:0]  value;
    } entry_t;

    // Request to the shared divider
    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] dividend;
        logic [CFG_W-1:0]  divisor;
    } div_req_t;

    // Response from the shared divider
    typedef struct packed {
        logic             done;
        logic [CFG_W-1:0] remainder;
    } div_rsp_t;

endpackage

// ----- rtl/core/rswr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module rswr_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/rswr_mod_unit.sv -----
// Restoring divider that returns the remainder of a 31-bit word by an 11-bit divisor.
module rswr_mod_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  rswr_pkg::div_req_t req,
    output rswr_pkg::div_rsp_t rsp
);
    import rswr_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [WORD_W-1:0]    quo_reg, quo_next;
    logic [CFG_W-1:0]     rem_reg, rem_next;
    logic [CFG_W-1:0]     div_reg, div_next;
    logic [CFG_W:0]       trial;

    // One restoring step: bring in the next dividend bit, subtract if it fits
    always_comb
    begin
        trial     = {rem_reg, quo_reg[WORD_W-1]};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_STEPS - 1);
            quo_next  = req.dividend;
            rem_next  = '0;
            div_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[WORD_W-2:0], 1'b0};
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = CFG_W'(trial - {1'b0, div_reg});
            end
            else
            begin
                rem_next = trial[CFG_W-1:0];
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;

endmodule

// ----- rtl/core/random_sample_without_replacement.sv -----
// Top level of the random sample block: sequencer, pool memory and shared divider.
//
// Draws distinct node indices without replacement by a partial Fisher-Yates
// shuffle. Each input item carries a 31-bit random word and a start flag; each
// yields one result item. A draw runs the bit-serial restoring divider that
// forms word modulo the remaining pool size, then one read of the chosen
// entry, one read of the tail entry and one write through the single pool RAM,
// plus the sequencer's set-up, check, output and idle steps; the next item is
// taken only after that, once the result register is free. A draw flagged
// exhausted skips the divider and the pool. A result that is not taken holds the
// sequencer in its output step. Pool entries carry an 8-bit epoch tag; a start
// moves to a new epoch, and every 255th start, like the end of reset, runs a
// sweep that clears the tags of all MAX_NODES entries, during which no input
// item is taken. Configuration writes are taken at any time but must only be
// issued while the block is idle.
module random_sample_without_replacement #(
    parameter int MAX_NODES = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data,
    // Input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [30:0] random_word, [31] zero
    input  logic        s_axis_tuser,   // [0] start_req
    // Result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [9:0] node_index, [19:10] draw_number, [23:20] zero
    output logic        m_axis_tlast,   // last_draw
    output logic        m_axis_tuser    // [0] exhausted
);
    import rswr_pkg::*;

`include "random_sample_without_replacement_macros.svh"

    localparam int AW      = $clog2(MAX_NODES);
    localparam int MAX_CAP = (MAX_NODES > 2047) ? 2047 : MAX_NODES;
    localparam logic [CFG_W-1:0] NODE_CAP  = CFG_W'(MAX_CAP);
    localparam logic [AW-1:0]    LAST_ADDR = AW'(MAX_NODES - 1);

    // Sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_PREP  = 4'd1;
    localparam logic [3:0] ST_CLEAR = 4'd2;
    localparam logic [3:0] ST_CHECK = 4'd3;
    localparam logic [3:0] ST_DIV   = 4'd4;
    localparam logic [3:0] ST_RPOS  = 4'd5;
    localparam logic [3:0] ST_RLAST = 4'd6;
    localparam logic [3:0] ST_WRITE = 4'd7;
    localparam logic [3:0] ST_OUT   = 4'd8;

    logic [3:0]        state_reg, state_next;
    logic [CFG_W-1:0]  node_count_reg, node_count_next;
    logic [CFG_W-1:0]  reserve_count_reg, reserve_count_next;
    logic              corner_mode_reg, corner_mode_next;
    logic [CFG_W-1:0]  draws_done_reg, draws_done_next;
    logic [EPOCH_W-1:0] epoch_reg, epoch_next;
    logic [AW-1:0]     clr_addr_reg, clr_addr_next;
    logic              clr_item_reg, clr_item_next;
    logic              out_valid_reg, out_valid_next;

    logic [WORD_W-1:0] word_reg, word_next;
    logic              start_reg, start_next;
    logic [AW-1:0]     pos_reg, pos_next;
    logic [NODE_W-1:0] chosen_reg, chosen_next;
    logic [NODE_W-1:0] res_node_reg, res_node_next;
    logic [NODE_W-1:0] res_draw_reg, res_draw_next;
    logic              res_last_reg, res_last_next;
    logic              res_exh_reg, res_exh_next;
    logic [NODE_W-1:0] out_node_reg, out_node_next;
    logic [NODE_W-1:0] out_draw_reg, out_draw_next;
    logic              out_last_reg, out_last_next;
    logic              out_exh_reg, out_exh_next;

    logic [CFG_W-1:0]  n_sat;
    logic [CFG_W-1:0]  pool_size;
    logic [CFG_W-1:0]  allowed_raw;
    logic [CFG_W-1:0]  allowed;
    logic [CFG_W-1:0]  remaining;
    logic [AW-1:0]     last_addr;
    logic [NODE_W-1:0] offset;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    entry_t            ram_wentry;
    logic [AW-1:0]     ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t            ram_rentry;

    div_req_t          div_req;
    div_rsp_t          div_rsp;

    // Value of a pool slot: the stored one if written in this epoch, else identity
    function automatic logic [NODE_W-1:0] live_value(
        input entry_t             ent,
        input logic [EPOCH_W-1:0] cur_epoch,
        input logic [AW-1:0]      addr,
        input logic [NODE_W-1:0]  offs
    );
        logic [NODE_W-1:0] res;
        if (ent.epoch == cur_epoch)
        begin
            res = ent.value;
        end
        else
        begin
            res = NODE_W'(addr) + offs;
        end
        return res;
    endfunction

    // Pool size, allowed draws and identity offset from the configuration
    always_comb
    begin
        n_sat = (node_count_reg > NODE_CAP) ? NODE_CAP : node_count_reg;
        if (corner_mode_reg)
        begin
            pool_size   = (n_sat >= CFG_W'(2)) ? n_sat - CFG_W'(2) : '0;
            allowed_raw = (reserve_count_reg >= CFG_W'(2)) ?
                          reserve_count_reg - CFG_W'(2) : '0;
            offset      = NODE_W'(1);
        end
        else
        begin
            pool_size   = n_sat;
            allowed_raw = reserve_count_reg;
            offset      = '0;
        end
        allowed   = (allowed_raw > pool_size) ? pool_size : allowed_raw;
        remaining = pool_size - draws_done_reg;
        last_addr = AW'(remaining - CFG_W'(1));
    end

    assign ram_rentry = entry_t'(ram_rdata);

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        draws_done_next = draws_done_reg;
        epoch_next      = epoch_reg;
        clr_addr_next   = clr_addr_reg;
        clr_item_next   = clr_item_reg;
        word_next       = word_reg;
        start_next      = start_reg;
        pos_next        = pos_reg;
        chosen_next     = chosen_reg;
        res_node_next   = res_node_reg;
        res_draw_next   = res_draw_reg;
        res_last_next   = res_last_reg;
        res_exh_next    = res_exh_reg;
        out_valid_next  = out_valid_reg;
        out_node_next   = out_node_reg;
        out_draw_next   = out_draw_reg;
        out_last_next   = out_last_reg;
        out_exh_next    = out_exh_reg;
        ram_we          = 1'b0;
        ram_waddr       = pos_reg;
        ram_wentry      = '{epoch: epoch_reg, value: '0};
        ram_raddr       = pos_reg;
        div_req         = '{start: 1'b0, dividend: word_reg, divisor: remaining};

        // The output register frees itself when the result is taken
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    word_next  = s_axis_tdata[WORD_W-1:0];
                    start_next = s_axis_tuser;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                // A start restarts the count and retires all written entries
                if (start_reg)
                begin
                    draws_done_next = '0;
                    if (epoch_reg == EPOCH_LAST)
                    begin
                        clr_addr_next = '0;
                        clr_item_next = 1'b1;
                        state_next    = ST_CLEAR;
                    end
                    else
                    begin
                        epoch_next = epoch_reg + 1'b1;
                        state_next = ST_CHECK;
                    end
                end
                else
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CLEAR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = clr_addr_reg;
                ram_wentry = '{epoch: EPOCH_CLEAR, value: '0};
                if (clr_addr_reg == LAST_ADDR)
                begin
                    epoch_next = EPOCH_FIRST;
                    state_next = clr_item_reg ? ST_CHECK : ST_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end
            ST_CHECK:
            begin
                if (draws_done_reg >= allowed)
                begin
                    res_node_next = '0;
                    res_draw_next = draws_done_reg[NODE_W-1:0];
                    res_last_next = 1'b0;
                    res_exh_next  = 1'b1;
                    state_next    = ST_OUT;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    pos_next   = AW'(div_rsp.remainder);
                    state_next = ST_RPOS;
                end
            end
            ST_RPOS:
            begin
                ram_raddr  = pos_reg;
                state_next = ST_RLAST;
            end
            ST_RLAST:
            begin
                // Read data now holds the chosen slot
                ram_raddr   = last_addr;
                chosen_next = live_value(ram_rentry, epoch_reg, pos_reg, offset);
                state_next  = ST_WRITE;
            end
            ST_WRITE:
            begin
                // Move the tail entry into the chosen slot
                ram_we          = 1'b1;
                ram_waddr       = pos_reg;
                ram_wentry      = '{epoch: epoch_reg,
                                    value: live_value(ram_rentry, epoch_reg,
                                                      last_addr, offset)};
                res_node_next   = chosen_reg;
                res_draw_next   = draws_done_reg[NODE_W-1:0];
                res_last_next   = (draws_done_reg + CFG_W'(1)) == allowed;
                res_exh_next    = 1'b0;
                draws_done_next = draws_done_reg + CFG_W'(1);
                state_next      = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_node_next  = res_node_reg;
                    out_draw_next  = res_draw_reg;
                    out_last_next  = res_last_reg;
                    out_exh_next   = res_exh_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Configuration register writes
    always_comb
    begin
        node_count_next    = node_count_reg;
        reserve_count_next = reserve_count_reg;
        corner_mode_next   = corner_mode_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_NODE_COUNT:    node_count_next    = cfg_data;
                REG_RESERVE_COUNT: reserve_count_next = cfg_data;
                REG_CORNER_MODE:   corner_mode_next   = cfg_data[0];
                default:           ;
            endcase
        end
    end

    // Control state; reset starts with a sweep of the pool tags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_CLEAR;
            node_count_reg    <= NODE_COUNT_RST;
            reserve_count_reg <= RESERVE_COUNT_RST;
            corner_mode_reg   <= 1'b0;
            draws_done_reg    <= '0;
            epoch_reg         <= EPOCH_CLEAR;
            clr_addr_reg      <= '0;
            clr_item_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            node_count_reg    <= node_count_next;
            reserve_count_reg <= reserve_count_next;
            corner_mode_reg   <= corner_mode_next;
            draws_done_reg    <= draws_done_next;
            epoch_reg         <= epoch_next;
            clr_addr_reg      <= clr_addr_next;
            clr_item_reg      <= clr_item_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        word_reg     <= word_next;
        start_reg    <= start_next;
        pos_reg      <= pos_next;
        chosen_reg   <= chosen_next;
        res_node_reg <= res_node_next;
        res_draw_reg <= res_draw_next;
        res_last_reg <= res_last_next;
        res_exh_reg  <= res_exh_next;
        out_node_reg <= out_node_next;
        out_draw_reg <= out_draw_next;
        out_last_reg <= out_last_next;
        out_exh_reg  <= out_exh_next;
    end

    // Pool memory
    rswr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_NODES)
    ) u_pool (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ENTRY_W'(ram_wentry)),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Shared modulo unit
    rswr_mod_unit u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Ports
    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_draw_reg, out_node_reg};
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_exh_reg;

    // An accepted item keeps the block busy in the following cycle
    `RSWR_ASSERT_NEXT(a_busy_after_accept, clk, rst_n,
        s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // The pool is written only by the tail move or the tag sweep
    `RSWR_ASSERT_IMPLIES(a_write_states, clk, rst_n, ram_we,
        state_reg == ST_WRITE || state_reg == ST_CLEAR)
    // The divider answers only while the sequencer waits for it
    `RSWR_ASSERT_IMPLIES(a_div_done_state, clk, rst_n, div_rsp.done, state_reg == ST_DIV)
    // An exhausted result never closes a run
    `RSWR_ASSERT_IMPLIES(a_exh_not_last, clk, rst_n,
        m_axis_tvalid && m_axis_tuser, !m_axis_tlast)

endmodule
